>>> sv/udp_forward_classify_checksum_top_macros.svh
// ----------------------------------------------------------------------------
// UDP forward classifier assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef UDP_FORWARD_CLASSIFY_CHECKSUM_TOP_MACROS_SVH
`define UDP_FORWARD_CLASSIFY_CHECKSUM_TOP_MACROS_SVH

// same-cycle implication
`define UFCC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UFCC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ufcc_pkg.sv
// ----------------------------------------------------------------------------
// UDP forward classifier package
// Request and result types, configuration layout, offsets and checksum fold.
// ----------------------------------------------------------------------------
package ufcc_pkg;

	localparam int MAX_UDP_BYTES_DEF = 1480;
	localparam int POS_W             = 11;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 32;

	localparam logic [POS_W-1:0] POS_MAX       = 11'd2047;
	localparam logic [POS_W-1:0] POS_ETYPE_HI  = 11'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO  = 11'd13;
	localparam logic [POS_W-1:0] POS_IP_FIRST  = 11'd14;
	localparam logic [POS_W-1:0] POS_PROTO     = 11'd23;
	localparam logic [POS_W-1:0] POS_UDP_START = 11'd34;
	localparam logic [POS_W-1:0] POS_DPORT_HI  = 11'd36;
	localparam logic [POS_W-1:0] POS_DPORT_LO  = 11'd37;
	localparam logic [POS_W-1:0] POS_ULEN_HI   = 11'd38;
	localparam logic [POS_W-1:0] POS_ULEN_LO   = 11'd39;
	localparam logic [POS_W-1:0] POS_UCSUM_HI  = 11'd40;
	localparam logic [POS_W-1:0] POS_UCSUM_LO  = 11'd41;
	localparam logic [POS_W-1:0] POS_MIN_LAST  = 11'd41;

	localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] LISTEN_PORT_RST = 16'd7999;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_PRESENT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LISTEN_PORT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_SRC_IP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_DST_IP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_PORT_INDEX = 3'd4;

	localparam logic [1:0] VERDICT_PASS     = 2'd0;
	localparam logic [1:0] VERDICT_DROP     = 2'd1;
	localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} frame_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [31:0] egress_index;
		logic [15:0] ip_header_sum;
		logic [15:0] udp_sum;
	} result_t;

	typedef struct packed {
		logic        entry_present;
		logic [15:0] listen_port;
		logic [31:0] new_src_ip;
		logic [31:0] new_dst_ip;
		logic [31:0] out_port_index;
	} cfg_t;

	// full one's complement fold of a sum below 2^34, then complement
	function automatic logic [15:0] fold_complement(input logic [33:0] s);
		logic [18:0] a;
		logic [16:0] b;
		logic [16:0] c;
		a = 19'(s[15:0]) + 19'(s[33:16]);
		b = 17'(a[15:0]) + 17'(a[18:16]);
		c = 17'(b[15:0]) + 17'(b[16]);
		return ~c[15:0];
	endfunction

endpackage

>>> sv/ufcc_parse.sv
// ----------------------------------------------------------------------------
// UDP forward classifier byte parser
// Per-byte classification and running checksums; builds the verdict on the
// last byte of a frame.
// ----------------------------------------------------------------------------
module ufcc_parse #(
	parameter int MAX_UDP_BYTES = ufcc_pkg::MAX_UDP_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  ufcc_pkg::frame_t item,
	input  ufcc_pkg::cfg_t   cfg,
	output ufcc_pkg::result_t result
);

	localparam int UDP_END_INT = 34 + MAX_UDP_BYTES;
	localparam logic [ufcc_pkg::POS_W-1:0] UDP_END = ufcc_pkg::POS_W'(UDP_END_INT);

	logic [ufcc_pkg::POS_W-1:0] pos_q, pos_n;
	logic [2:0]  flags_q, flags_n;
	logic [7:0]  held_q, held_n;
	logic [19:0] ip_acc_q, ip_acc_n;
	logic [31:0] udp_acc_q, udp_acc_n;
	logic [17:0] addr_sum_q;

	logic [7:0]  b;
	logic [15:0] word_part;
	logic        udp_take;
	logic        udp_len;
	logic        redirect;
	logic        match;
	logic [15:0] usum_raw;

	always_comb begin
		b         = item.data_byte;
		word_part = pos_q[0] ? {8'd0, b} : {b, 8'd0};

		held_n = held_q;
		if (pos_q == ufcc_pkg::POS_ETYPE_HI || pos_q == ufcc_pkg::POS_DPORT_HI) begin
			held_n = b;
		end

		flags_n = flags_q;
		if (pos_q == ufcc_pkg::POS_ETYPE_LO && {held_q, b} == ufcc_pkg::ETYPE_IPV4) begin
			flags_n[0] = 1'b1;
		end
		if (pos_q == ufcc_pkg::POS_PROTO && b == ufcc_pkg::PROTO_UDP) begin
			flags_n[1] = 1'b1;
		end
		if (pos_q == ufcc_pkg::POS_DPORT_LO && {held_q, b} == cfg.listen_port) begin
			flags_n[2] = 1'b1;
		end

		ip_acc_n = ip_acc_q;
		if (pos_q >= ufcc_pkg::POS_IP_FIRST && pos_q <= ufcc_pkg::POS_PROTO) begin
			ip_acc_n = ip_acc_q + 20'(word_part);
		end

		// UDP checksum field skipped; length word counted twice (pseudo header)
		udp_take = pos_q >= ufcc_pkg::POS_UDP_START && pos_q < ufcc_pkg::POS_MAX
			&& pos_q < UDP_END
			&& pos_q != ufcc_pkg::POS_UCSUM_HI && pos_q != ufcc_pkg::POS_UCSUM_LO;
		udp_len  = pos_q == ufcc_pkg::POS_ULEN_HI || pos_q == ufcc_pkg::POS_ULEN_LO;
		udp_acc_n = udp_acc_q;
		if (udp_take) begin
			udp_acc_n = udp_len ? udp_acc_q + {15'd0, word_part, 1'b0}
				: udp_acc_q + 32'(word_part);
		end

		pos_n = (pos_q < ufcc_pkg::POS_MAX) ? pos_q + ufcc_pkg::POS_W'(1) : pos_q;

		match    = pos_q >= ufcc_pkg::POS_MIN_LAST && flags_n == 3'b111;
		redirect = match && cfg.entry_present;
		usum_raw = ufcc_pkg::fold_complement(34'(udp_acc_n) + 34'(addr_sum_q)
			+ 34'(ufcc_pkg::PROTO_UDP));

		result = '0;
		if (match && !cfg.entry_present) begin
			result.verdict = ufcc_pkg::VERDICT_DROP;
		end else if (redirect) begin
			result.verdict       = ufcc_pkg::VERDICT_REDIRECT;
			result.egress_index  = cfg.out_port_index;
			result.ip_header_sum = ufcc_pkg::fold_complement(34'(ip_acc_n) + 34'(addr_sum_q));
			result.udp_sum       = (usum_raw == 16'd0) ? 16'hffff : usum_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			flags_q    <= '0;
			held_q     <= '0;
			ip_acc_q   <= '0;
			udp_acc_q  <= '0;
			addr_sum_q <= '0;
		end else begin
			addr_sum_q <= 18'(cfg.new_src_ip[31:16]) + 18'(cfg.new_src_ip[15:0])
				+ 18'(cfg.new_dst_ip[31:16]) + 18'(cfg.new_dst_ip[15:0]);
			if (advance) begin
				if (item.last_byte) begin
					pos_q     <= '0;
					flags_q   <= '0;
					held_q    <= '0;
					ip_acc_q  <= '0;
					udp_acc_q <= '0;
				end else begin
					pos_q     <= pos_n;
					flags_q   <= flags_n;
					held_q    <= held_n;
					ip_acc_q  <= ip_acc_n;
					udp_acc_q <= udp_acc_n;
				end
			end
		end
	end

endmodule

>>> sv/udp_forward_classify_checksum_top.sv
// ----------------------------------------------------------------------------
// UDP forward classifier with checksum rewrite
// Path: the last byte of a frame is taken into the input register, then its
// verdict goes from the parser into the result register.
// Throughput: one frame byte per cycle, but a last byte waits while a verdict is held;
// the parser and both running sums update in a single pass per byte.
// Reset: clears frame state, handshake state and configuration to defaults.
// ----------------------------------------------------------------------------
`include "udp_forward_classify_checksum_top_macros.svh"

module udp_forward_classify_checksum_top #(
	parameter int MAX_UDP_BYTES = ufcc_pkg::MAX_UDP_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              frame_valid,
	output logic                              frame_ready,
	input  ufcc_pkg::frame_t                  frame,
	output logic                              result_valid,
	input  logic                              result_ready,
	output ufcc_pkg::result_t                 result,
	input  logic                              wr_en,
	input  logic [ufcc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [ufcc_pkg::CFG_DATA_W-1:0]   wr_data
);

	ufcc_pkg::cfg_t    cfg_q;
	ufcc_pkg::frame_t  item_s1;
	logic              valid_s1;
	logic              advance;
	ufcc_pkg::result_t result_n;
	ufcc_pkg::result_t result_q;
	logic              result_valid_q;

	assign advance = valid_s1 && (!item_s1.last_byte || !result_valid_q || result_ready);
	assign frame_ready = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_present  <= 1'b0;
			cfg_q.listen_port    <= ufcc_pkg::LISTEN_PORT_RST;
			cfg_q.new_src_ip     <= '0;
			cfg_q.new_dst_ip     <= '0;
			cfg_q.out_port_index <= '0;
		end else if (wr_en) begin
			case (wr_index)
				ufcc_pkg::REG_ENTRY_PRESENT: begin
					cfg_q.entry_present <= wr_data[0];
				end
				ufcc_pkg::REG_LISTEN_PORT: begin
					cfg_q.listen_port <= wr_data[15:0];
				end
				ufcc_pkg::REG_NEW_SRC_IP: begin
					cfg_q.new_src_ip <= wr_data;
				end
				ufcc_pkg::REG_NEW_DST_IP: begin
					cfg_q.new_dst_ip <= wr_data;
				end
				ufcc_pkg::REG_OUT_PORT_INDEX: begin
					cfg_q.out_port_index <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && frame_ready) begin
			item_s1 <= frame;
		end
	end

	ufcc_parse #(
		.MAX_UDP_BYTES(MAX_UDP_BYTES)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			result_q <= result_n;
		end
	end

	`UFCC_ASSERT_NOW(a_mid_byte_flows, valid_s1 && !item_s1.last_byte, advance,
		"mid-frame byte stalled")
	`UFCC_ASSERT_NOW(a_stall_cause, !frame_ready,
		valid_s1 && item_s1.last_byte && result_valid_q && !result_ready,
		"input stalled without a held verdict")
	`UFCC_ASSERT_NEXT(a_result_loaded, advance && item_s1.last_byte, result_valid_q,
		"last byte left no verdict")
	`UFCC_ASSERT_NOW(a_non_redirect_zero,
		result_valid_q && result_q.verdict != ufcc_pkg::VERDICT_REDIRECT,
		result_q.egress_index == '0 && result_q.ip_header_sum == '0
			&& result_q.udp_sum == '0,
		"non-redirect verdict with nonzero fields")
	`UFCC_ASSERT_NOW(a_verdict_code, result_valid_q,
		result_q.verdict == ufcc_pkg::VERDICT_PASS
			|| result_q.verdict == ufcc_pkg::VERDICT_DROP
			|| result_q.verdict == ufcc_pkg::VERDICT_REDIRECT,
		"verdict code out of range")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP forward classifier testbench
// Sends Ethernet frames byte by byte: a directed table of frame shapes and
// settings, then random frames under random settings. A per-byte bench parser
// predicts each verdict and both rewritten checksums unless a table row gives
// its own; results are checked in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int UDP_LIMIT = ufcc_pkg::MAX_UDP_BYTES_DEF;
	localparam int BYTE_GOAL = 1400;
	localparam int VERDICT_GOAL = 6;
	localparam int LONG_HOLD = 200;

	typedef enum logic [2:0] {
		SHAPE_MATCH, SHAPE_BAD_ETYPE, SHAPE_BAD_PROTO, SHAPE_BAD_PORT, SHAPE_NOISE
	} frame_shape_t;

	typedef struct packed {
		logic [10:0] pos;
		logic [2:0]  flags;
		logic [7:0]  held;
		logic [19:0] ip_acc;
		logic [31:0] udp_acc;
	} parse_state_t;

	typedef struct packed {
		logic [1:0]        cfg_pick;
		logic [11:0]       len;
		frame_shape_t      shape;
		logic              ones;
		logic              zero_usum;
		logic              typed;
		ufcc_pkg::result_t want;
	} stim_row_t;

	localparam ufcc_pkg::result_t RES_PASS = '{ufcc_pkg::VERDICT_PASS, 32'd0, 16'd0, 16'd0};
	localparam ufcc_pkg::result_t RES_DROP = '{ufcc_pkg::VERDICT_DROP, 32'd0, 16'd0, 16'd0};

	localparam ufcc_pkg::cfg_t DIR_CFGS [3] = '{
		'{1'b0, ufcc_pkg::LISTEN_PORT_RST, 32'd0, 32'd0, 32'd0},
		'{1'b1, 16'h0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
		'{1'b1, 16'hffff, 32'd0, 32'd0, 32'd0}
	};

	localparam stim_row_t DIR_ROWS [16] = '{
		'{2'd0, 12'd1,    SHAPE_MATCH,     1'b0, 1'b0, 1'b1, RES_PASS},
		'{2'd0, 12'd41,   SHAPE_MATCH,     1'b0, 1'b0, 1'b1, RES_PASS},
		'{2'd0, 12'd42,   SHAPE_MATCH,     1'b0, 1'b0, 1'b1, RES_DROP},
		'{2'd0, 12'd60,   SHAPE_BAD_ETYPE, 1'b0, 1'b0, 1'b1, RES_PASS},
		'{2'd0, 12'd60,   SHAPE_BAD_PROTO, 1'b0, 1'b0, 1'b1, RES_PASS},
		'{2'd0, 12'd60,   SHAPE_BAD_PORT,  1'b0, 1'b0, 1'b1, RES_PASS},
		'{2'd1, 12'd42,   SHAPE_MATCH,     1'b0, 1'b0, 1'b0, RES_PASS},
		'{2'd1, 12'd43,   SHAPE_MATCH,     1'b1, 1'b0, 1'b0, RES_PASS},
		'{2'd1, 12'd200,  SHAPE_MATCH,     1'b1, 1'b0, 1'b0, RES_PASS},
		'{2'd1, 12'd60,   SHAPE_MATCH,     1'b0, 1'b1, 1'b0, RES_PASS},
		'{2'd1, 12'd41,   SHAPE_MATCH,     1'b1, 1'b0, 1'b1, RES_PASS},
		'{2'd1, 12'd70,   SHAPE_NOISE,     1'b0, 1'b0, 1'b0, RES_PASS},
		'{2'd2, 12'd42,   SHAPE_MATCH,     1'b0, 1'b0, 1'b0, RES_PASS},
		'{2'd2, 12'd61,   SHAPE_MATCH,     1'b0, 1'b0, 1'b0, RES_PASS},
		'{2'd2, 12'd100,  SHAPE_BAD_PORT,  1'b0, 1'b0, 1'b1, RES_PASS},
		'{2'd2, 12'd2,    SHAPE_MATCH,     1'b0, 1'b0, 1'b1, RES_PASS}
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           frame_valid = 1'b0;
	logic                           frame_ready;
	ufcc_pkg::frame_t               frame = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	ufcc_pkg::result_t              result;
	logic                           wr_en = 1'b0;
	logic [ufcc_pkg::CFG_IDX_W-1:0]  wr_index = '0;
	logic [ufcc_pkg::CFG_DATA_W-1:0] wr_data = '0;

	ufcc_pkg::cfg_t    live_cfg = DIR_CFGS[0];
	parse_state_t      parser = '0;
	ufcc_pkg::result_t verdict_q[$];
	logic [7:0]        frame_bytes[$];
	int                bad_results = 0;
	int                bytes_sent = 0;
	logic              hold_req = 1'b0;

	udp_forward_classify_checksum_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] ones_fold(input logic [63:0] x);
		while (x[63:16] != '0)
			x = {48'd0, x[15:0]} + (x >> 16);
		return x[15:0];
	endfunction

	function automatic void parse_frame_byte(inout parse_state_t s, input ufcc_pkg::cfg_t c,
			input ufcc_pkg::frame_t f, output logic fired, output ufcc_pkg::result_t r);
		logic [10:0] p;
		logic [7:0]  b;
		logic [31:0] v;
		logic [63:0] addr;
		logic [15:0] usum;
		int          k;
		p = s.pos;
		b = f.data_byte;
		fired = 1'b0;
		r = RES_PASS;
		if (p == ufcc_pkg::POS_ETYPE_HI || p == ufcc_pkg::POS_DPORT_HI)
			s.held = b;
		if (p == ufcc_pkg::POS_ETYPE_LO && {s.held, b} == ufcc_pkg::ETYPE_IPV4)
			s.flags[0] = 1'b1;
		if (p == ufcc_pkg::POS_PROTO && b == ufcc_pkg::PROTO_UDP)
			s.flags[1] = 1'b1;
		if (p == ufcc_pkg::POS_DPORT_LO && {s.held, b} == c.listen_port)
			s.flags[2] = 1'b1;
		if (p >= ufcc_pkg::POS_IP_FIRST && p <= ufcc_pkg::POS_PROTO)
			s.ip_acc = s.ip_acc + (p[0] ? {12'd0, b} : {4'd0, b, 8'd0});
		if (p >= ufcc_pkg::POS_UDP_START && p < ufcc_pkg::POS_MAX) begin
			k = int'(p) - int'(ufcc_pkg::POS_UDP_START);
			if (k < UDP_LIMIT && p != ufcc_pkg::POS_UCSUM_HI
					&& p != ufcc_pkg::POS_UCSUM_LO) begin
				v = p[0] ? {24'd0, b} : {16'd0, b, 8'd0};
				s.udp_acc += v;
				if (p == ufcc_pkg::POS_ULEN_HI || p == ufcc_pkg::POS_ULEN_LO)
					s.udp_acc += v;
			end
		end
		if (p != ufcc_pkg::POS_MAX)
			s.pos = p + 11'd1;
		if (f.last_byte) begin
			fired = 1'b1;
			if (p >= ufcc_pkg::POS_MIN_LAST && s.flags == 3'b111) begin
				if (!c.entry_present) begin
					r.verdict = ufcc_pkg::VERDICT_DROP;
				end else begin
					addr = 64'(c.new_src_ip[31:16]) + 64'(c.new_src_ip[15:0])
						+ 64'(c.new_dst_ip[31:16]) + 64'(c.new_dst_ip[15:0]);
					r.verdict = ufcc_pkg::VERDICT_REDIRECT;
					r.egress_index = c.out_port_index;
					r.ip_header_sum = ~ones_fold(64'(s.ip_acc) + addr);
					usum = ~ones_fold(64'(s.udp_acc) + addr + 64'(ufcc_pkg::PROTO_UDP));
					r.udp_sum = (usum == 16'd0) ? 16'hffff : usum;
				end
			end
			s = '0;
		end
	endfunction

	function automatic void build_frame(input int len, input frame_shape_t shape,
			input logic ones);
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [15:0] port;
		frame_bytes.delete();
		for (int i = 0; i < len; i++)
			frame_bytes.push_back(ones ? 8'hff : 8'($urandom));
		if (shape == SHAPE_NOISE)
			return;
		etype = ufcc_pkg::ETYPE_IPV4;
		proto = ufcc_pkg::PROTO_UDP;
		port = live_cfg.listen_port;
		if (shape == SHAPE_BAD_ETYPE)
			etype ^= 16'($urandom_range(1, 65535));
		if (shape == SHAPE_BAD_PROTO)
			proto ^= 8'($urandom_range(1, 255));
		if (shape == SHAPE_BAD_PORT)
			port ^= 16'($urandom_range(1, 65535));
		if (len > int'(ufcc_pkg::POS_ETYPE_LO)) begin
			frame_bytes[ufcc_pkg::POS_ETYPE_HI] = etype[15:8];
			frame_bytes[ufcc_pkg::POS_ETYPE_LO] = etype[7:0];
		end
		if (len > int'(ufcc_pkg::POS_PROTO))
			frame_bytes[ufcc_pkg::POS_PROTO] = proto;
		if (len > int'(ufcc_pkg::POS_DPORT_LO)) begin
			frame_bytes[ufcc_pkg::POS_DPORT_HI] = port[15:8];
			frame_bytes[ufcc_pkg::POS_DPORT_LO] = port[7:0];
		end
	endfunction

	// pick the final payload word so that the folded UDP sum comes out all ones
	function automatic void tune_zero_udp_sum();
		parse_state_t      s;
		ufcc_pkg::frame_t  f;
		logic              fired;
		ufcc_pkg::result_t r;
		logic [15:0]       w;
		int                n;
		s = '0;
		n = frame_bytes.size();
		frame_bytes[n-2] = 8'd0;
		frame_bytes[n-1] = 8'd0;
		for (int i = 0; i < n; i++) begin
			f.data_byte = frame_bytes[i];
			f.last_byte = (i == n - 1);
			parse_frame_byte(s, live_cfg, f, fired, r);
		end
		w = 16'hffff - ~r.udp_sum;
		frame_bytes[n-2] = w[15:8];
		frame_bytes[n-1] = w[7:0];
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic ufcc_pkg::cfg_t random_cfg();
		ufcc_pkg::cfg_t c;
		c.entry_present = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 3))
			0: c.listen_port = 16'h0000;
			1: c.listen_port = 16'hffff;
			2: c.listen_port = ufcc_pkg::LISTEN_PORT_RST;
			default: c.listen_port = 16'($urandom);
		endcase
		c.new_src_ip = pick_word();
		c.new_dst_ip = pick_word();
		c.out_port_index = pick_word();
		return c;
	endfunction

	task automatic write_reg(input logic [ufcc_pkg::CFG_IDX_W-1:0] idx,
			input logic [ufcc_pkg::CFG_DATA_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input ufcc_pkg::cfg_t c);
		write_reg(ufcc_pkg::REG_ENTRY_PRESENT, {$urandom} & ~32'd1 | 32'(c.entry_present));
		write_reg(ufcc_pkg::REG_LISTEN_PORT, {16'($urandom), c.listen_port});
		write_reg(ufcc_pkg::REG_NEW_SRC_IP, c.new_src_ip);
		write_reg(ufcc_pkg::REG_NEW_DST_IP, c.new_dst_ip);
		write_reg(ufcc_pkg::REG_OUT_PORT_INDEX, c.out_port_index);
		// unmapped indexes must leave the settings alone
		for (int i = int'(ufcc_pkg::REG_OUT_PORT_INDEX) + 1; i < (1 << ufcc_pkg::CFG_IDX_W);
				i++)
			write_reg(ufcc_pkg::CFG_IDX_W'(i), $urandom);
		wr_en <= 1'b0;
		live_cfg = c;
	endtask

	task automatic drain();
		frame_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_byte(input ufcc_pkg::frame_t f, input int gap, input logic typed,
			input ufcc_pkg::result_t want);
		logic              fired;
		ufcc_pkg::result_t r;
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_valid <= 1'b1;
		frame <= f;
		do @(posedge clk); while (!frame_ready);
		parse_frame_byte(parser, live_cfg, f, fired, r);
		if (fired)
			verdict_q.push_back(typed ? want : r);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic typed, input ufcc_pkg::result_t want,
			input logic calm);
		ufcc_pkg::frame_t f;
		int               n;
		n = frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			f.data_byte = frame_bytes[i];
			f.last_byte = (i == n - 1);
			push_byte(f, calm ? 0 : $urandom_range(0, 4), typed && f.last_byte, want);
		end
	endtask

	// result side: per-result stalls, quiet stretches, one long hold-off
	initial begin
		int                stall_left;
		int                hold_left;
		logic              hold_used;
		logic              calm;
		ufcc_pkg::result_t exp_r;
		stall_left = 0;
		hold_left = 0;
		hold_used = 1'b0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				if (verdict_q.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("unexpected result: verdict %0d egress %h ip %h udp %h",
							result.verdict, result.egress_index, result.ip_header_sum,
							result.udp_sum);
				end else begin
					exp_r = verdict_q.pop_front();
					if (result.verdict !== exp_r.verdict
							|| result.egress_index !== exp_r.egress_index
							|| result.ip_header_sum !== exp_r.ip_header_sum
							|| result.udp_sum !== exp_r.udp_sum) begin
						bad_results++;
						if (bad_results <= 10)
							$display({"mismatch (exp/got): verdict %0d/%0d egress %h/%h",
								" ip %h/%h udp %h/%h"},
								exp_r.verdict, result.verdict,
								exp_r.egress_index, result.egress_index,
								exp_r.ip_header_sum, result.ip_header_sum,
								exp_r.udp_sum, result.udp_sum);
					end
				end
				stall_left = calm ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 19) == 0)
					calm = !calm;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			result_ready <= (stall_left == 0) && (hold_left == 0);
		end
	end

	initial begin
		stim_row_t    row;
		int           cur_pick;
		int           rand_frames;
		int           sel;
		int           len;
		frame_shape_t shape;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_pick = 0;
		foreach (DIR_ROWS[i]) begin
			row = DIR_ROWS[i];
			if (int'(row.cfg_pick) != cur_pick) begin
				drain();
				apply_cfg(DIR_CFGS[row.cfg_pick]);
				cur_pick = row.cfg_pick;
			end
			build_frame(row.len, row.shape, row.ones);
			if (row.zero_usum)
				tune_zero_udp_sum();
			send_frame(row.typed, row.want, 1'b0);
		end

		rand_frames = 0;
		while (bytes_sent < BYTE_GOAL || rand_frames < VERDICT_GOAL) begin
			if (rand_frames % 4 == 0) begin
				drain();
				apply_cfg(random_cfg());
			end
			if (rand_frames == 2) begin
				// back-to-back tiny frames while results are held off
				hold_req <= 1'b1;
				repeat (24) begin
					build_frame($urandom_range(1, 3), SHAPE_MATCH, 1'b0);
					send_frame(1'b0, RES_PASS, 1'b1);
				end
			end
			sel = $urandom_range(0, 19);
			if (sel <= 12)
				shape = SHAPE_MATCH;
			else if (sel <= 14)
				shape = SHAPE_NOISE;
			else if (sel == 15)
				shape = SHAPE_BAD_ETYPE;
			else if (sel == 16)
				shape = SHAPE_BAD_PROTO;
			else
				shape = SHAPE_BAD_PORT;
			if (sel >= 18)
				len = $urandom_range(1, 41);
			else if ($urandom_range(0, 24) == 0)
				len = $urandom_range(91, 160);
			else
				len = $urandom_range(42, 90);
			build_frame(len, shape, $urandom_range(0, 9) == 0);
			send_frame(1'b0, RES_PASS, $urandom_range(0, 3) == 0);
			rand_frames++;
		end

		frame_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (bad_results == 0 && verdict_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
